FILE: rtl/core/umlaut_glyph_transcoder_defines.svh
// assertion helpers for the transcoder top module
`ifndef UMLAUT_GLYPH_TRANSCODER_DEFINES_SVH
`define UMLAUT_GLYPH_TRANSCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UGT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ugt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ugt_pkg;

  // most glyphs one input byte can produce
  localparam int unsigned MAX_GLYPHS = 6;
  localparam int unsigned ESC_LEN    = 6;

  localparam logic [7:0] GLYPH_SPACE = 8'd32;
  localparam logic [7:0] GLYPH_AMP   = 8'd38;
  localparam logic [7:0] LEAD_C3     = 8'd195;
  localparam logic [7:0] ESC_START   = 8'h5c;
  localparam logic [7:0] ASCII_TOP   = 8'd127;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic       last_glyph;
  } out_word_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [2:0] escape_matched;
    logic       utf8_lead_seen;
  } ugt_state_t;

  // characters of the escape sequence \u0026
  function automatic logic [7:0] esc_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h5c;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h30;
      3'd4:    c = 8'h32;
      3'd5:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // second byte of a c3 utf-8 pair
  function automatic logic [7:0] map_pair(input logic [7:0] b);
    logic [7:0] g;
    case (b)
      8'ha4:   g = 8'd127;
      8'h84:   g = 8'd128;
      8'hb6:   g = 8'd129;
      8'h96:   g = 8'd130;
      8'hbc:   g = 8'd131;
      8'h9c:   g = 8'd132;
      8'h9f:   g = 8'd133;
      default: g = GLYPH_SPACE;
    endcase
    return g;
  endfunction

  // single code-page byte
  function automatic logic [7:0] map_single(input logic [7:0] b);
    logic [7:0] g;
    case (b)
      8'd132:  g = 8'd127;
      8'd142:  g = 8'd128;
      8'd148:  g = 8'd129;
      8'd153:  g = 8'd130;
      8'd129:  g = 8'd131;
      8'd154:  g = 8'd132;
      8'd225:  g = 8'd133;
      default: g = GLYPH_SPACE;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ugt_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module ugt_decode (
  input  ugt_pkg::in_word_t   in_word,
  input  ugt_pkg::ugt_state_t st,
  output ugt_pkg::ugt_state_t st_nxt,
  output ugt_pkg::out_word_t  list [ugt_pkg::MAX_GLYPHS],
  output logic [2:0]          count
);
  import ugt_pkg::*;

  logic [7:0] b;
  logic       eot;
  logic       in_prefix;
  logic [2:0] flush_k;
  logic       g_valid;
  logic [7:0] g;
  logic [2:0] tail_m;
  logic       tail_space;
  logic [2:0] base;

  assign b   = in_word.text_byte;
  assign eot = in_word.end_of_text;

  // partial escape waiting for its next character
  assign in_prefix = (st.escape_matched != 3'd0) && (st.escape_matched < 3'(ESC_LEN));

  // classify the byte against the held state
  always_comb begin
    flush_k    = 3'd0;
    g_valid    = 1'b0;
    g          = GLYPH_SPACE;
    tail_m     = 3'd0;
    tail_space = 1'b0;
    st_nxt     = '0;
    if (st.utf8_lead_seen) begin
      g_valid = 1'b1;
      g       = map_pair(b);
    end else if (in_prefix && (b == esc_char(st.escape_matched))) begin
      if (st.escape_matched == 3'(ESC_LEN - 1)) begin
        g_valid = 1'b1;
        g       = GLYPH_AMP;
      end else begin
        st_nxt.escape_matched = st.escape_matched + 3'd1;
      end
    end else begin
      // broken prefix is flushed, then the byte is taken fresh
      if (in_prefix) begin
        flush_k = st.escape_matched;
      end
      if (b == ESC_START) begin
        st_nxt.escape_matched = 3'd1;
      end else if (b == LEAD_C3) begin
        st_nxt.utf8_lead_seen = 1'b1;
      end else begin
        g_valid = 1'b1;
        g       = (b < ASCII_TOP) ? b : map_single(b);
      end
    end
    // end of string drains whatever is held
    if (eot) begin
      tail_m     = st_nxt.escape_matched;
      tail_space = st_nxt.utf8_lead_seen;
      st_nxt     = '0;
    end
  end

  assign base  = flush_k + {2'b00, g_valid};
  assign count = base + tail_m + {2'b00, tail_space};

  // lay out flushed prefix, main glyph, drained tail
  always_comb begin
    logic [2:0] pc;
    logic [2:0] q;
    for (int p = 0; p < MAX_GLYPHS; p++) begin
      pc = 3'(p);
      q  = pc - base;
      if (pc < flush_k) begin
        list[p].glyph = esc_char(pc);
      end else if (g_valid && (pc == flush_k)) begin
        list[p].glyph = g;
      end else if ((pc >= base) && (q < tail_m)) begin
        list[p].glyph = esc_char(q);
      end else begin
        list[p].glyph = GLYPH_SPACE;
      end
      list[p].last_glyph = eot && (pc == (count - 3'd1));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/umlaut_glyph_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Text byte to font glyph transcoder. Each accepted byte yields zero to six
// glyph words: bytes below 127 pass through, \u0026 becomes '&', c3 utf-8 pairs and
// single code-page umlaut bytes map to glyphs 127..133, other high bytes give
// a space. A byte that yields at most one glyph is taken every cycle while
// out_stall is low, with the output register decoupling the two sides. A byte
// that yields several glyphs (a broken escape flush or an end-of-text drain)
// places the extra glyphs in a six-entry holding buffer that is drained one
// word per cycle while out_stall is low, and in_stall is high while that
// buffer is non-empty. Output words are registered.
module umlaut_glyph_transcoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ugt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ugt_pkg::out_word_t out_word
);
  import ugt_pkg::*;
  `include "umlaut_glyph_transcoder_defines.svh"

  ugt_state_t st_r;
  ugt_state_t st_dec;
  ugt_state_t st_nxt;
  out_word_t  list [MAX_GLYPHS];
  logic [2:0] count;

  out_word_t  pend_r   [MAX_GLYPHS];
  out_word_t  pend_nxt [MAX_GLYPHS];
  logic [2:0] pend_cnt_r;
  logic [2:0] pend_cnt_nxt;
  out_word_t  out_word_r;
  out_word_t  out_word_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  logic       accept;
  logic       out_load;

  ugt_decode u_decode (
    .in_word (in_word),
    .st      (st_r),
    .st_nxt  (st_dec),
    .list    (list),
    .count   (count)
  );

  assign in_stall  = (pend_cnt_r != 3'd0);
  assign accept    = in_valid && !in_stall;
  assign out_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // decoder state advances on each accepted word
  assign st_nxt = accept ? st_dec : st_r;

  // output register fed from holding buffer first, else from the decoder
  always_comb begin
    pend_nxt      = pend_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    if (pend_cnt_r != 3'd0) begin
      if (out_load) begin
        out_word_nxt  = pend_r[0];
        out_valid_nxt = 1'b1;
        for (int i = 0; i < MAX_GLYPHS - 1; i++) begin
          pend_nxt[i] = pend_r[i + 1];
        end
        pend_cnt_nxt = pend_cnt_r - 3'd1;
      end
    end else if (accept && (count != 3'd0)) begin
      if (out_load) begin
        out_word_nxt  = list[0];
        out_valid_nxt = 1'b1;
        for (int i = 0; i < MAX_GLYPHS - 1; i++) begin
          pend_nxt[i] = list[i + 1];
        end
        pend_cnt_nxt = count - 3'd1;
      end else begin
        pend_nxt     = list;
        pend_cnt_nxt = count;
      end
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      pend_cnt_r  <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_word_r <= out_word_nxt;
  end

  `UGT_ASSERT_NOW(a_lead_no_escape, st_r.utf8_lead_seen, st_r.escape_matched == 3'd0, "lead and escape both held")
  `UGT_ASSERT_NOW(a_escape_range, 1'b1, st_r.escape_matched < 3'd6, "escape count out of range")
  `UGT_ASSERT_NOW(a_pend_range, 1'b1, pend_cnt_r <= 3'd6, "holding buffer overfilled")
  `UGT_ASSERT_NEXT(a_eot_clears, accept && in_word.end_of_text, st_r == '0, "state not cleared at end of text")

endmodule

`default_nettype wire
